>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, types and register indexes of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BlockBits = 24;
  localparam int CntW      = $clog2(BlockBits + 1);
  localparam int RegIdxW   = 2;

  typedef logic [BlockBits-1:0] block_t;
  typedef logic [RegIdxW-1:0]   reg_idx_t;

  localparam reg_idx_t RegExponent = reg_idx_t'(0);
  localparam reg_idx_t RegModulus  = reg_idx_t'(1);

  localparam block_t ExponentReset = block_t'(1);
  localparam block_t ModulusReset  = '1;

endpackage

>>> rtl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial interleaved modular multiplier: product = a * b mod m.
// One bit of a per cycle, MSB first; needs b < m, or b = 1 with any m >= 1.
// ----------------------------------------------------------------------------
module mexp_modmul
  import mexp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  block_t a_i,
  input  block_t b_i,
  input  block_t m_i,
  output logic   done_o,
  output block_t product_o
);

  block_t             a_q, a_d;
  block_t             b_q, b_d;
  block_t             m_q, m_d;
  block_t             p_q, p_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;

  logic [BlockBits+1:0] addend;
  logic [BlockBits+1:0] sum;
  logic [BlockBits+1:0] m1;
  logic [BlockBits+1:0] m2;
  logic [BlockBits+1:0] sub1;
  logic [BlockBits+1:0] sub2;

  // Partial remainder stays below m, so 2p + b < 3m: at most two subtractions.
  always_comb begin
    addend = a_q[BlockBits-1] ? {2'b00, b_q} : '0;
    sum    = {1'b0, p_q, 1'b0} + addend;
    m1     = {2'b00, m_q};
    m2     = {1'b0, m_q, 1'b0};
    sub1   = sum - m1;
    sub2   = sum - m2;
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      m_d   = m_i;
      p_d   = '0;
      cnt_d = CntW'(BlockBits);
    end else if (cnt_q != '0) begin
      a_d   = {a_q[BlockBits-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      priority if (sum >= m2) begin
        p_d = sub2[BlockBits-1:0];
      end else if (sum >= m1) begin
        p_d = sub1[BlockBits-1:0];
      end else begin
        p_d = sum[BlockBits-1:0];
      end
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    p_q <= p_d;
  end

  assign done_o    = done_q;
  assign product_o = p_q;

endmodule

>>> rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Right-to-left square-and-multiply: result = message ^ exponent mod modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Write the exponent (index 0) and modulus (index 1) through the cfg port
//   while the unit is idle. Reset loads exponent 1 and modulus all ones.
//   Input items arrive on message_block_i with in_valid_i / in_ready_o; one
//   result item per input leaves on result_block_o with out_valid_o /
//   out_ready_i.
//   Each item first reduces the message modulo the modulus, then walks the
//   exponent bits from LSB up: a multiply into the accumulator for each set
//   bit and a squaring of the base for each bit below the highest set one.
//   Every multiply runs on one shared bit-serial modular multiplier;
//   exponent zero or modulus zero skip it and go straight to StFinish.
//   One item is in flight at a time: in_ready_o is high only when the
//   sequencer is idle, so the next item can be taken in the cycle after
//   a result is posted. A finished result sits in the output register;
//   when the receiver stalls, the next item is still accepted and computed,
//   and then waits for the output register to empty before the unit goes
//   idle again.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  reg_idx_t cfg_idx_i,
  input  block_t   cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  block_t   message_block_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output block_t   result_block_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StReduce = 3'd1;
  localparam logic [2:0] StBit    = 3'd2;
  localparam logic [2:0] StMulAcc = 3'd3;
  localparam logic [2:0] StSquare = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0] state_q, state_d;
  block_t     exp_key_q, exp_key_d;
  block_t     mod_key_q, mod_key_d;
  block_t     e_q, e_d;
  block_t     acc_q, acc_d;
  block_t     base_q, base_d;
  logic       out_valid_q, out_valid_d;
  block_t     result_q, result_d;

  logic   mul_start;
  block_t mul_a;
  block_t mul_b;
  logic   mul_done;
  block_t mul_prod;
  logic   in_fire;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    exp_key_d = exp_key_q;
    mod_key_d = mod_key_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == RegExponent) begin
        exp_key_d = cfg_data_i;
      end else if (cfg_idx_i == RegModulus) begin
        mod_key_d = cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    acc_d       = acc_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    mul_start   = 1'b0;
    mul_a       = acc_q;
    mul_b       = base_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          e_d = exp_key_q;
          if (exp_key_q == '0) begin
            acc_d   = block_t'(1);
            state_d = StFinish;
          end else if (mod_key_q == '0) begin
            acc_d   = '0;
            state_d = StFinish;
          end else begin
            // Reduce the message first: message * 1 mod m.
            acc_d     = block_t'(1);
            mul_start = 1'b1;
            mul_a     = message_block_i;
            mul_b     = block_t'(1);
            state_d   = StReduce;
          end
        end
      end
      StReduce: begin
        if (mul_done) begin
          base_d  = mul_prod;
          state_d = StBit;
        end
      end
      StBit: begin
        mul_start = 1'b1;
        if (e_q[0]) begin
          state_d = StMulAcc;
        end else begin
          mul_a   = base_q;
          state_d = StSquare;
        end
      end
      StMulAcc: begin
        if (mul_done) begin
          acc_d = mul_prod;
          // Skip the squaring after the top set bit.
          if (e_q[BlockBits-1:1] == '0) begin
            state_d = StFinish;
          end else begin
            mul_start = 1'b1;
            mul_a     = base_q;
            state_d   = StSquare;
          end
        end
      end
      StSquare: begin
        mul_a = base_q;
        if (mul_done) begin
          base_d  = mul_prod;
          e_d     = {1'b0, e_q[BlockBits-1:1]};
          state_d = StBit;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          result_d    = acc_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .m_i       (mod_key_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      exp_key_q   <= ExponentReset;
      mod_key_q   <= ModulusReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_key_q   <= exp_key_d;
      mod_key_q   <= mod_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    result_q <= result_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = result_q;

endmodule

>>> rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation unit, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker
  import mexp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     cfg_we_i,
  input reg_idx_t cfg_idx_i,
  input block_t   cfg_data_i,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input block_t   message_block_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input block_t   result_block_o
);

  // Busy after taking an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("unit ready right after accepting an item");

  // A new result only appears at the end of a busy period.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result item appeared without work in progress");

  // Hold a stalled result.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_block_o)))
    else $error("stalled result item dropped or changed");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);
